@@ src/stp_pkg.sv @@
// Shared types and constants for the stepper step pulse generator.
// No dependencies; used by stp_ctrl, stp_dpath and the top level.
package stp_pkg;

	localparam int COUNT_BITS  = 24;
	localparam int PERIOD_BITS = 26;
	localparam int PROD_BITS   = 28;
	localparam int DCNT_BITS   = 5;
	localparam int PULSE_TICKS = 5;
	localparam int CFG_BITS    = 12;
	localparam int CFG_IDX_BITS = 3;

	// Ticks in one minute; the period dividend.
	localparam logic [PERIOD_BITS-1:0] MINUTE_TICKS = PERIOD_BITS'(60000000);
	localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = PERIOD_BITS'(1000);

	// Configuration register indexes.
	localparam logic [CFG_IDX_BITS-1:0] REG_SPEED_RPM      = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_FULL_STEPS     = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_MICROSTEP      = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_ACTIVE_LOW     = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_MOTOR_ENABLED  = 3'd4;

	// Input command codes.
	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_MOVE = 1'b1;

	typedef struct packed {
		logic                  command;
		logic [COUNT_BITS-1:0] step_count;
		logic                  direction;
	} req_t;

	typedef struct packed {
		logic                  step_pin;
		logic                  dir_pin;
		logic                  enable_pin;
		logic                  busy_res;
		logic [COUNT_BITS-1:0] steps_remaining;
		logic                  rejected;
	} rsp_t;

	// Controller to datapath.
	typedef struct packed {
		logic load;
		logic mul1;
		logic mul2;
		logic div_init;
		logic div_step;
		logic emit;
	} dp_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic is_move;
		logic running;
		logic prod_zero;
		logic div_last;
	} dp_stat_t;

endpackage

@@ src/stp_ctrl.sv @@
// Sequencing state machine for the stepper step pulse generator.
// Depends on stp_pkg; drives stp_dpath through dp_cmd_t and owns the result valid.
module stp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	input  stp_pkg::dp_stat_t stat,
	output stp_pkg::dp_cmd_t  cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MUL1 = 3'd1;
	localparam logic [2:0] S_MUL2 = 3'd2;
	localparam logic [2:0] S_DCHK = 3'd3;
	localparam logic [2:0] S_DIV  = 3'd4;
	localparam logic [2:0] S_EMIT = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       slot_free;

	assign slot_free = !out_valid_q || !rsp_stall;
	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_MUL1;
				end
			end
			S_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d  = (stat.is_move && !stat.running) ? S_MUL2 : S_EMIT;
			end
			S_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d  = S_DCHK;
			end
			S_DCHK: begin
				if (stat.prod_zero) begin
					state_d = S_EMIT;
				end else begin
					cmd.div_init = 1'b1;
					state_d      = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) state_d = S_EMIT;
			end
			S_EMIT: begin
				if (slot_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) out_valid_q <= 1'b1;
			else if (!rsp_stall) out_valid_q <= 1'b0;
		end
	end

endmodule

@@ src/stp_dpath.sv @@
// Datapath of the stepper step pulse generator: configuration, multiplier,
// radix-2 period divider, step state and the result register. Depends on stp_pkg.
module stp_dpath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [stp_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [stp_pkg::CFG_BITS-1:0]        cfg_data,
	input  stp_pkg::req_t                       req_data,
	input  stp_pkg::dp_cmd_t                    cmd,
	output stp_pkg::dp_stat_t                   stat,
	output stp_pkg::rsp_t                       rsp_data
);

	localparam int PB = stp_pkg::PERIOD_BITS;
	localparam int QB = stp_pkg::PROD_BITS;
	localparam int CB = stp_pkg::COUNT_BITS;
	localparam int DB = stp_pkg::DCNT_BITS;

	// configuration
	logic [11:0] speed_rpm_q;
	logic [9:0]  full_steps_q;
	logic [5:0]  microstep_q;
	logic        active_low_q;
	logic        motor_enabled_q;

	// latched item
	stp_pkg::req_t req_q;

	// period computation
	logic [21:0]                     p1_q;
	logic [QB-1:0]                   prod_q;
	logic [QB-1:0]                   rem_q;
	logic [PB-1:0]                   quo_q;
	logic [stp_pkg::DCNT_BITS-1:0]   dcnt_q;
	logic [QB:0]                     trial;
	logic [QB:0]                     diff;

	// step state
	logic [PB-1:0] period_q;
	logic          pulse_q;
	logic [PB-1:0] timer_q;
	logic [CB-1:0] steps_q;
	logic          dir_q;
	logic          running_q;

	logic [PB-1:0] n_period;
	logic          n_pulse;
	logic [PB-1:0] n_timer;
	logic [CB-1:0] n_steps;
	logic          n_dir;
	logic          n_running;
	logic          n_rejected;
	logic [PB-1:0] t1;
	logic [CB-1:0] wsteps;

	stp_pkg::rsp_t out_q;

	assign stat.is_move   = (req_q.command == stp_pkg::CMD_MOVE);
	assign stat.running   = running_q;
	assign stat.prod_zero = (prod_q == '0);
	assign stat.div_last  = (dcnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_rpm_q     <= '0;
			full_steps_q    <= 10'd200;
			microstep_q     <= 6'd1;
			active_low_q    <= 1'b1;
			motor_enabled_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				stp_pkg::REG_SPEED_RPM:     speed_rpm_q     <= cfg_data;
				stp_pkg::REG_FULL_STEPS:    full_steps_q    <= cfg_data[9:0];
				stp_pkg::REG_MICROSTEP:     microstep_q     <= cfg_data[5:0];
				stp_pkg::REG_ACTIVE_LOW:    active_low_q    <= cfg_data[0];
				stp_pkg::REG_MOTOR_ENABLED: motor_enabled_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Restoring division, one quotient bit per step, MSB first.
	assign trial = {rem_q, stp_pkg::MINUTE_TICKS[dcnt_q]};
	assign diff  = trial - {1'b0, prod_q};

	always_ff @(posedge clk) begin
		if (cmd.load) req_q <= req_data;
		if (cmd.mul1) p1_q <= 22'(speed_rpm_q) * 22'(full_steps_q);
		if (cmd.mul2) prod_q <= QB'(p1_q) * QB'(microstep_q);
		if (cmd.div_init) begin
			rem_q  <= '0;
			quo_q  <= '0;
			dcnt_q <= DB'(PB - 1);
		end else if (cmd.div_step) begin
			if (!diff[QB]) begin
				rem_q <= diff[QB-1:0];
				quo_q <= {quo_q[PB-2:0], 1'b1};
			end else begin
				rem_q <= trial[QB-1:0];
				quo_q <= {quo_q[PB-2:0], 1'b0};
			end
			dcnt_q <= dcnt_q - 1'b1;
		end
		if (cmd.emit) out_q <= '{
			step_pin:        (n_running & n_pulse) ^ active_low_q,
			dir_pin:         n_dir,
			enable_pin:      motor_enabled_q ^ active_low_q,
			busy_res:        n_running,
			steps_remaining: n_steps,
			rejected:        n_rejected
		};
	end

	assign rsp_data = out_q;

	// Next step state for the item in hand.
	always_comb begin
		n_period   = period_q;
		n_pulse    = pulse_q;
		n_timer    = timer_q;
		n_steps    = steps_q;
		n_dir      = dir_q;
		n_running  = running_q;
		n_rejected = 1'b0;
		t1         = (timer_q != '0) ? timer_q - 1'b1 : timer_q;
		wsteps     = pulse_q ? steps_q - 1'b1 : steps_q;
		if (req_q.command == stp_pkg::CMD_MOVE) begin
			if (running_q) begin
				n_rejected = 1'b1;
			end else begin
				if (prod_q != '0) n_period = quo_q;
				n_dir   = req_q.direction;
				n_steps = req_q.step_count;
				if (req_q.step_count != '0) begin
					n_running = 1'b1;
					n_pulse   = 1'b1;
					n_timer   = PB'(stp_pkg::PULSE_TICKS);
				end
			end
		end else if (running_q) begin
			n_timer = t1;
			if (t1 == '0) begin
				n_steps = wsteps;
				n_pulse = 1'b0;
				if (pulse_q && period_q != '0) begin
					n_timer = period_q;
				end else if (wsteps != '0) begin
					n_pulse = 1'b1;
					n_timer = PB'(stp_pkg::PULSE_TICKS);
				end else begin
					n_running = 1'b0;
					n_timer   = '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q  <= stp_pkg::PERIOD_RESET;
			pulse_q   <= 1'b0;
			timer_q   <= '0;
			steps_q   <= '0;
			dir_q     <= 1'b0;
			running_q <= 1'b0;
		end else if (cmd.emit) begin
			period_q  <= n_period;
			pulse_q   <= n_pulse;
			timer_q   <= n_timer;
			steps_q   <= n_steps;
			dir_q     <= n_dir;
			running_q <= n_running;
		end
	end

endmodule

@@ src/stepper_step_pulse_generator_top.sv @@
// Top level of the stepper step pulse generator.
// Depends on stp_pkg, stp_ctrl and stp_dpath.
//
// Usage:
//   req channel (req_valid/req_stall/req_data) carries one beat per
//   microsecond tick (command 0) or per move request (command 1, with
//   step_count and direction). Every request beat yields exactly one beat on
//   the rsp channel (rsp_valid/rsp_stall/rsp_data) with the pin levels for
//   the coming tick, busy flag, steps remaining and a reject flag. The user
//   writes configuration registers (cfg_we/cfg_index/cfg_data) only while
//   idle, not enforced by the block; a write takes effect on the next beat.
// Sequence: a tick beat or a refused move passes load, the first multiply
//   and result emission. A move taken while idle also passes the second
//   multiply and the divider check and, when the speed product is nonzero,
//   the radix-2 period divider, one quotient bit per cycle. One request is
//   in flight at a time; the next is taken after the result is emitted.
// Reset: arst_n clears the step state (period 1000 ticks, idle) and loads
//   the register defaults; no result beat is pending.
// Stall: the result register holds its beat while rsp_stall is high; a new
//   request is still taken and worked on, and waits only at its final step.
module stepper_step_pulse_generator_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               req_valid,
	output logic                               req_stall,
	input  stp_pkg::req_t                      req_data,
	output logic                               rsp_valid,
	input  logic                               rsp_stall,
	output stp_pkg::rsp_t                      rsp_data,
	input  logic                               cfg_we,
	input  logic [stp_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [stp_pkg::CFG_BITS-1:0]       cfg_data
);

	stp_pkg::dp_cmd_t  cmd;
	stp_pkg::dp_stat_t stat;

	// Sequence load, multiply, divide and result emission.
	stp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Hold configuration, step state and the result register.
	stp_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_data  (req_data),
		.cmd       (cmd),
		.stat      (stat),
		.rsp_data  (rsp_data)
	);

`ifndef SYNTHESIS
	// A rejected move only happens while a move is running, which it leaves alone.
	a_reject_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.rejected |-> rsp_data.busy_res)
		else $error("rejected beat without busy");

	// An idle block has no steps outstanding.
	a_idle_no_steps: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_data.busy_res |-> rsp_data.steps_remaining == '0)
		else $error("steps remaining while idle");

	// One request at a time: after an accept the block stalls.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("second request taken while busy");
`endif

endmodule
